FILE: design/scpa_pkg.sv
// Shared types, codes and helpers for the size-class pool allocator.
`timescale 1ns / 1ps
package scpa_pkg;

  localparam int SIZE_W  = 23;
  localparam int CLASS_W = 4;
  localparam int SLOT_W  = 6;

  // Largest chunk of the top class, in bytes
  localparam int unsigned LAST_CHUNK_BYTES = 65 * 100000;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_ZERO        = 3'd1,
    ST_TOO_LARGE   = 3'd2,
    ST_FULL        = 3'd3,
    ST_BAD_RELEASE = 3'd4
  } status_t;

  // What the back end must do with a queued item
  typedef enum logic [1:0] {
    K_ALLOC   = 2'd0,
    K_RELEASE = 2'd1,
    K_FAIL    = 2'd2
  } kind_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_EXEC = 1'b1
  } back_state_t;

  typedef struct packed {
    op_t                operation;
    logic [SIZE_W-1:0]  request_size;
    logic [CLASS_W-1:0] release_class;
    logic [SLOT_W-1:0]  release_slot;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [CLASS_W-1:0] granted_class;
    logic [SLOT_W-1:0]  granted_slot;
  } rsp_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic [CLASS_W-1:0] cls;
    logic [SLOT_W-1:0]  slot;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Index of the lowest set bit of a 64-bit vector (0 when none is set)
  function automatic logic [SLOT_W-1:0] lowest_set(input logic [63:0] v);
    logic [63:0]       iso;
    logic [SLOT_W-1:0] idx;
    iso = v & (~v + 64'd1);
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      idx = idx | (iso[i] ? SLOT_W'(i) : '0);
    end
    return idx;
  endfunction

endpackage

FILE: design/scpa_front.sv
// Front end: checks each item and picks the size class of an allocate.
`timescale 1ns / 1ps
module scpa_front #(
  parameter int NUM_CLASSES     = 12,
  parameter int SLOTS_PER_CLASS = 64,
  parameter int MIN_CHUNK_BYTES = 4
) (
  input  scpa_pkg::req_t   request,
  output scpa_pkg::entry_t entry
);
  import scpa_pkg::*;

  function automatic int unsigned chunk_bytes(input int c);
    if (c == NUM_CLASSES - 1) begin
      return LAST_CHUNK_BYTES;
    end
    return int'(MIN_CHUNK_BYTES) << c;
  endfunction

  logic [63:0] fits;
  logic        found;
  logic        bad_release;

  // One compare per class, then the first class that fits
  always_comb begin
    fits = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      fits[c] = 32'(request.request_size) <= chunk_bytes(c);
    end
  end

  assign found = |fits;
  assign bad_release = (32'(request.release_class) >= 32'(NUM_CLASSES)) ||
                       (32'(request.release_slot) >= 32'(SLOTS_PER_CLASS));

  always_comb begin
    entry.kind   = K_FAIL;
    entry.status = ST_OK;
    entry.cls    = '0;
    entry.slot   = '0;
    case (request.operation)
      OP_ALLOC: begin
        if (request.request_size == '0) begin
          entry.status = ST_ZERO;
        end else if (!found) begin
          entry.status = ST_TOO_LARGE;
        end else begin
          entry.kind = K_ALLOC;
          entry.cls  = CLASS_W'(lowest_set(fits));
        end
      end
      OP_RELEASE: begin
        if (bad_release) begin
          entry.status = ST_BAD_RELEASE;
        end else begin
          entry.kind = K_RELEASE;
          entry.cls  = request.release_class;
          entry.slot = request.release_slot;
        end
      end
      default: begin
        entry.status = ST_BAD_RELEASE;
      end
    endcase
  end

endmodule

FILE: design/scpa_queue.sv
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps
module scpa_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  scpa_pkg::entry_t    push_entry,
  input  logic                pop,
  output scpa_pkg::entry_t    head,
  output scpa_pkg::q_status_t qstat
);
  import scpa_pkg::*;

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign head        = slots[rd_ptr];
  assign qstat.full  = count == (QPTR_W + 1)'(QDEPTH);
  assign qstat.empty = count == '0;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: design/scpa_back.sv
// Back end: read-modify-write of the class occupancy words.
`timescale 1ns / 1ps
module scpa_back #(
  parameter int NUM_CLASSES     = 12,
  parameter int SLOTS_PER_CLASS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  scpa_pkg::entry_t    head,
  input  scpa_pkg::q_status_t qstat,
  output logic                pop,
  output logic                done,
  output scpa_pkg::rsp_t      result
);
  import scpa_pkg::*;

  localparam int CIW = $clog2(NUM_CLASSES);
  localparam int SIW = $clog2(SLOTS_PER_CLASS);

  logic [SLOTS_PER_CLASS-1:0] occ [NUM_CLASSES];

  back_state_t                state;
  back_state_t                state_next;
  entry_t                     ent;
  logic [SLOTS_PER_CLASS-1:0] word;

  logic [SLOTS_PER_CLASS-1:0] free_bits;
  logic [SLOT_W-1:0]          pick;
  logic [SLOTS_PER_CLASS-1:0] pick_bit;
  logic [SLOTS_PER_CLASS-1:0] rel_bit;
  logic                       do_write;
  logic [SLOTS_PER_CLASS-1:0] word_next;
  rsp_t                       result_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!qstat.empty) state_next = B_EXEC;
      B_EXEC:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop = 1'b0;
    case (state)
      B_IDLE:  pop = !qstat.empty;
      B_EXEC:  pop = 1'b0;
      default: pop = 1'b0;
    endcase
  end

  // Lowest free slot and the updated word
  assign free_bits = ~word;
  assign pick      = lowest_set(64'(free_bits));
  assign pick_bit  = SLOTS_PER_CLASS'(1) << pick[SIW-1:0];
  assign rel_bit   = SLOTS_PER_CLASS'(1) << ent.slot[SIW-1:0];

  always_comb begin
    do_write    = 1'b0;
    word_next   = word;
    result_next = '{status: ent.status, granted_class: '0, granted_slot: '0};
    case (ent.kind)
      K_ALLOC: begin
        if (free_bits == '0) begin
          result_next.status = ST_FULL;
        end else begin
          do_write                  = 1'b1;
          word_next                 = word | pick_bit;
          result_next.status        = ST_OK;
          result_next.granted_class = ent.cls;
          result_next.granted_slot  = pick;
        end
      end
      K_RELEASE: begin
        if ((word & rel_bit) == '0) begin
          result_next.status = ST_BAD_RELEASE;
        end else begin
          do_write           = 1'b1;
          word_next          = word & ~rel_bit;
          result_next.status = ST_OK;
        end
      end
      default: ;
    endcase
  end

  // Sequencer and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == B_EXEC;
    end
  end

  // Item latch, registered word read and result register
  always_ff @(posedge clk) begin
    if (pop) begin
      ent  <= head;
      word <= occ[head.cls[CIW-1:0]];
    end
    if (state == B_EXEC) begin
      result <= result_next;
    end
  end

  // Occupancy words
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        occ[c] <= '0;
      end
    end else if (state == B_EXEC && do_write) begin
      occ[ent.cls[CIW-1:0]] <= word_next;
    end
  end

endmodule

FILE: design/size_class_pool_allocator.sv
// Top level of the size-class pool allocator.
//
// Usage: drive request and raise start; the item is taken at a rising edge
// where start is high and busy is low. An allocate picks the first size
// class whose chunk covers request_size and grants its lowest free slot; a
// release frees the named slot. Every item gives exactly one result on
// result, shown for one cycle with done high, in the order items were taken.
// When the back end is free, an accepted item goes from the queue to the item
// latch and registered word read, then to result with done. The back end
// ends its read-modify-write of one class occupancy word (registered read,
// priority encode, write-back) before taking the next item. A 2-entry queue
// sits between the classifying front and back ends; busy is high while full.
// Reset (synchronous, active high) frees every slot, empties the queue and
// clears done, all in the reset cycle; no clearing pass follows.
// The receiver cannot stall: each result must be taken while done is high.
`timescale 1ns / 1ps
module size_class_pool_allocator #(
  parameter int NUM_CLASSES     = 12,
  parameter int SLOTS_PER_CLASS = 64,
  parameter int MIN_CHUNK_BYTES = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  scpa_pkg::req_t request,
  output logic           done,
  output scpa_pkg::rsp_t result
);
  import scpa_pkg::*;

  entry_t    front_entry;
  entry_t    head;
  q_status_t qstat;
  logic      push;
  logic      pop;

  assign busy = qstat.full;
  assign push = start && !qstat.full;

  scpa_front #(
    .NUM_CLASSES    (NUM_CLASSES),
    .SLOTS_PER_CLASS(SLOTS_PER_CLASS),
    .MIN_CHUNK_BYTES(MIN_CHUNK_BYTES)
  ) u_front (
    .request(request),
    .entry  (front_entry)
  );

  scpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(front_entry),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  scpa_back #(
    .NUM_CLASSES    (NUM_CLASSES),
    .SLOTS_PER_CLASS(SLOTS_PER_CLASS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .done  (done),
    .result(result)
  );

endmodule

FILE: design/scpa_checker.sv
// Port-level checks for the size-class pool allocator, bound to the top.
`timescale 1ns / 1ps
module scpa_checker #(
  parameter int NUM_CLASSES     = 12,
  parameter int SLOTS_PER_CLASS = 64
) (
  input logic           clk,
  input logic           rst,
  input logic           busy,
  input logic           done,
  input scpa_pkg::rsp_t result
);
  import scpa_pkg::*;

  // The back end returns to idle after each item, so results never come back to back
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done high in two consecutive cycles");

  // A failed result carries no grant
  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |->
      (result.granted_class == '0 && result.granted_slot == '0))
    else $error("grant fields set on a failed result");

  // A grant names an existing class and slot
  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_OK) |->
      (32'(result.granted_class) < 32'(NUM_CLASSES) &&
       32'(result.granted_slot) < 32'(SLOTS_PER_CLASS)))
    else $error("granted class or slot out of range");

  // Reset empties the queue and the result strobe
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("busy or done high right after reset");

endmodule

bind size_class_pool_allocator scpa_checker #(
  .NUM_CLASSES    (NUM_CLASSES),
  .SLOTS_PER_CLASS(SLOTS_PER_CLASS)
) u_scpa_checker (.*);

FILE: test/size_class_pool_allocator_test.sv
// Self-checking testbench for the size-class pool allocator.
`timescale 1ns / 1ps
module size_class_pool_allocator_test;
  import scpa_pkg::*;

  localparam int NCLS        = 12;
  localparam int NSLOTS      = 64;
  localparam int MIN_BYTES   = 4;
  localparam int RAND_ITEMS  = 1700;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic done;
  rsp_t result;

  // Predictor state: one occupancy word per class
  logic [NSLOTS-1:0] slot_busy_map [NCLS];
  rsp_t              grants_due [$];
  row_t              directed_rows [$];
  int                errors;
  int                mismatches;
  int                cycle_count;

  size_class_pool_allocator #(
    .NUM_CLASSES     (NCLS),
    .SLOTS_PER_CLASS (NSLOTS),
    .MIN_CHUNK_BYTES (MIN_BYTES)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Chunk size of a class in bytes
  function automatic int unsigned chunk_limit(input int c);
    if (c >= NCLS - 1) return LAST_CHUNK_BYTES;
    return MIN_BYTES << c;
  endfunction

  // Works out the result of one item and updates the occupancy words
  function automatic rsp_t next_grant(input req_t r);
    rsp_t rsp;
    int   c;
    int   s;
    rsp = '{status: ST_OK, granted_class: '0, granted_slot: '0};
    if (r.operation == OP_ALLOC) begin
      if (r.request_size == 0) begin
        rsp.status = ST_ZERO;
      end else begin
        c = 0;
        while (c < NCLS && r.request_size > chunk_limit(c)) c++;
        if (c == NCLS) begin
          rsp.status = ST_TOO_LARGE;
        end else if (&slot_busy_map[c]) begin
          rsp.status = ST_FULL;
        end else begin
          s = 0;
          for (int i = NSLOTS - 1; i >= 0; i--) begin
            if (!slot_busy_map[c][i]) s = i;
          end
          slot_busy_map[c][s] = 1'b1;
          rsp.granted_class   = CLASS_W'(c);
          rsp.granted_slot    = SLOT_W'(s);
        end
      end
    end else begin
      if (r.release_class >= NCLS || r.release_slot >= NSLOTS ||
          !slot_busy_map[r.release_class][r.release_slot]) begin
        rsp.status = ST_BAD_RELEASE;
      end else begin
        slot_busy_map[r.release_class][r.release_slot] = 1'b0;
      end
    end
    return rsp;
  endfunction

  function automatic void add_row(input op_t op, input int unsigned sz, input int cls,
                                  input int slot, input bit typed, input status_t st,
                                  input int gc, input int gs);
    row_t row;
    row.req.operation     = op;
    row.req.request_size  = SIZE_W'(sz);
    row.req.release_class = CLASS_W'(cls);
    row.req.release_slot  = SLOT_W'(slot);
    row.typed             = typed;
    row.want              = '{status: st, granted_class: CLASS_W'(gc),
                              granted_slot: SLOT_W'(gs)};
    directed_rows.push_back(row);
  endfunction

  // Present one item after a gap, hold it until taken, queue its expected result.
  // Entered and left just after a falling edge.
  task automatic send_item(input req_t r, input bit typed, input rsp_t want, input int gap);
    rsp_t predicted;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    request = r;
    start   = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = next_grant(r);
    grants_due.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (grants_due.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d class %0d slot %0d",
                   result.status, result.granted_class, result.granted_slot);
      end else begin
        want = grants_due.pop_front();
        if (result.status !== want.status || result.granted_class !== want.granted_class ||
            result.granted_slot !== want.granted_slot) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d class %0d slot %0d, got %0d %0d %0d",
                     want.status, want.granted_class, want.granted_slot,
                     result.status, result.granted_class, result.granted_slot);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("size_class_pool_allocator verification failed");
      $finish;
    end
  end

  initial begin
    req_t        r;
    rsp_t        none;
    int          pick;
    int          cls;
    int          slot;
    int          fill_left;
    int          fill_cls;
    bit          no_gaps;
    int          gap;
    int unsigned lo;
    int unsigned hi;

    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    errors      = 0;
    mismatches  = 0;
    cycle_count = 0;
    none        = '0;
    fill_left   = 0;
    fill_cls    = 0;
    no_gaps     = 1'b0;
    for (int c = 0; c < NCLS; c++) slot_busy_map[c] = '0;

    // Directed rows: extremes, every status except full, releases of each kind
    add_row(OP_ALLOC,   0,        0,  0,  1, ST_ZERO,        0,  0);
    add_row(OP_ALLOC,   1,        0,  0,  1, ST_OK,          0,  0);
    add_row(OP_ALLOC,   4,        0,  0,  1, ST_OK,          0,  1);
    add_row(OP_ALLOC,   5,        0,  0,  1, ST_OK,          1,  0);
    add_row(OP_ALLOC,   4096,     0,  0,  1, ST_OK,          10, 0);
    add_row(OP_ALLOC,   4097,     0,  0,  1, ST_OK,          11, 0);
    add_row(OP_ALLOC,   6500000,  0,  0,  1, ST_OK,          11, 1);
    add_row(OP_ALLOC,   6500001,  0,  0,  1, ST_TOO_LARGE,   0,  0);
    add_row(OP_ALLOC,   8388607,  15, 63, 1, ST_TOO_LARGE,   0,  0);
    add_row(OP_RELEASE, 0,        0,  0,  1, ST_OK,          0,  0);
    add_row(OP_RELEASE, 0,        0,  0,  1, ST_BAD_RELEASE, 0,  0);
    add_row(OP_RELEASE, 0,        12, 0,  1, ST_BAD_RELEASE, 0,  0);
    add_row(OP_RELEASE, 8388607,  15, 63, 1, ST_BAD_RELEASE, 0,  0);
    add_row(OP_RELEASE, 8388607,  11, 1,  1, ST_OK,          0,  0);
    add_row(OP_RELEASE, 0,        5,  63, 1, ST_BAD_RELEASE, 0,  0);
    add_row(OP_ALLOC,   2,        0,  0,  0, ST_OK,          0,  0);
    add_row(OP_ALLOC,   3000,     0,  0,  0, ST_OK,          0,  0);
    add_row(OP_ALLOC,   2048,     0,  0,  0, ST_OK,          0,  0);
    add_row(OP_ALLOC,   8,        0,  0,  0, ST_OK,          0,  0);
    add_row(OP_RELEASE, 0,        1,  0,  0, ST_OK,          0,  0);
    add_row(OP_ALLOC,   6,        0,  0,  0, ST_OK,          0,  0);

    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want,
                $urandom_range(0, 10));

    // Random items: mostly class-aimed allocates and releases of live slots,
    // with bursts that fill a class and some noise
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (fill_left == 0 && $urandom_range(0, 199) == 0) begin
        fill_cls  = $urandom_range(0, NCLS - 1);
        fill_left = $urandom_range(64, 72);
      end
      r.operation     = OP_ALLOC;
      r.request_size  = '0;
      r.release_class = CLASS_W'($urandom_range(0, 15));
      r.release_slot  = SLOT_W'($urandom_range(0, 63));
      pick            = (fill_left > 0) ? 40 : $urandom_range(0, 99);
      if (fill_left > 0) begin
        fill_left--;
        cls = fill_cls;
      end else begin
        cls = $urandom_range(0, NCLS - 1);
      end
      if (pick < 4) begin
        r.request_size = '0;
      end else if (pick < 8) begin
        r.request_size = SIZE_W'($urandom_range(0, 8388607));
      end else if (pick < 12) begin
        r.operation = OP_RELEASE;
      end else if (pick < 55) begin
        lo = (cls == 0) ? 1 : chunk_limit(cls - 1) + 1;
        hi = chunk_limit(cls);
        case ($urandom_range(0, 3))
          0:       r.request_size = SIZE_W'(lo);
          1:       r.request_size = SIZE_W'(hi);
          default: r.request_size = SIZE_W'($urandom_range(lo, hi));
        endcase
      end else begin
        // Release a live slot where there is one
        r.operation = OP_RELEASE;
        for (int k = 0; k < NCLS; k++) begin
          if (slot_busy_map[cls] == '0) cls = (cls + 1) % NCLS;
        end
        if (slot_busy_map[cls] != '0) begin
          slot = $urandom_range(0, NSLOTS - 1);
          while (!slot_busy_map[cls][slot]) slot = (slot + 1) % NSLOTS;
          r.release_class = CLASS_W'(cls);
          r.release_slot  = SLOT_W'(slot);
        end
      end
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      send_item(r, 1'b0, none, gap);
    end
    start = 1'b0;

    // Drain, then keep watching for stray results
    while (grants_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    errors += grants_due.size();
    if (errors == 0) begin
      $display("size_class_pool_allocator verification clean");
    end else begin
      $display("size_class_pool_allocator verification failed");
    end
    $finish;
  end

endmodule
